/* rtl/kli_pkg.sv */
// kli_pkg: shared types, command codes and sequencer states of the
// keyframe linear interpolator; no dependencies
package kli_pkg;

  localparam int MAX_KEYS_DEF = 128;
  localparam int DATA_W       = 32;
  localparam int FRAC_W       = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SCAN,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] kt;
    logic signed [DATA_W-1:0] kv;
  } key_t;

endpackage

/* rtl/kli_if.sv */
// kli_in_if / kli_out_if: valid-ready channels of the interpolator
// depends on kli_pkg for field widths
interface kli_in_if import kli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [1:0]               cmd;
  logic signed [DATA_W-1:0] time_in;
  logic signed [DATA_W-1:0] key_value;

  modport source (output valid, cmd, time_in, key_value, input ready);
  modport sink   (input valid, cmd, time_in, key_value, output ready);
endinterface

interface kli_out_if import kli_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] interp_value;
  logic                     table_empty;

  modport source (output valid, interp_value, table_empty, input ready);
  modport sink   (input valid, interp_value, table_empty, output ready);
endinterface

/* rtl/kli_key_mem.sv */
// kli_key_mem: keyframe store, one write port and one registered read port
// depends on kli_pkg for key_t
module kli_key_mem import kli_pkg::*; #(
  parameter int DEPTH = MAX_KEYS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  key_t          wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output key_t          rdata_r
);

  key_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

/* rtl/kli_frac_div.sv */
// kli_frac_div: restoring divider, one quotient bit per cycle,
// gives floor(num * 2^FRAC_W / den) for num < den; depends on kli_pkg
module kli_frac_div import kli_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [DATA_W-1:0] num,
  input  logic [DATA_W-1:0] den,
  output logic              done_r,
  output logic [FRAC_W-1:0] quo_r
);

  localparam int CNT_W = $clog2(FRAC_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rem_r, rem_nxt;
  logic [DATA_W-1:0] den_r, den_nxt;
  logic [FRAC_W-1:0] quo_nxt;
  logic [DATA_W:0]   rem2;
  logic              take;

  assign rem2 = {rem_r, 1'b0};
  assign take = rem2 >= {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(FRAC_W);
      rem_nxt  = num;
      den_nxt  = den;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = take ? DATA_W'(rem2 - {1'b0, den_r}) : rem2[DATA_W-1:0];
      quo_nxt = {quo_r[FRAC_W-2:0], take};
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    quo_r <= quo_nxt;
  end

endmodule

/* rtl/keyframe_linear_interpolator_unit.sv */
// keyframe_linear_interpolator_unit: top level, command sequencer and datapath
// depends on kli_pkg, kli_if, kli_key_mem and kli_frac_div
//
// Keeps up to MAX_KEYS (time, value) keyframes, both signed Q16.16, in
// insertion order and takes one command per input beat: clear (empties the
// table), add (appends a key, dropped when the table is full) and query.
// A query gives one output beat: 0 with table_empty set for an empty table,
// the first value at or before the first key, the last value at or after
// the last key, and otherwise a linear blend inside the first segment that
// holds the time (the last value if none does), with an unsigned Q0.16
// fraction, rounded toward minus infinity. Clear and add may come back to
// back. A query on an empty table goes straight to the result; otherwise
// the first key and then the last key are checked before the segments are
// scanned from key one through the single read port of the key store (one
// key a cycle), and a blend then runs the 16-step serial fraction divider.
// The key store is not cleared after reset; only the key count is. A result
// waits in the output register until taken; a new beat is accepted meanwhile
// unless a second query finishes before the first result is taken.
module keyframe_linear_interpolator_unit import kli_pkg::*; #(
  parameter int MAX_KEYS = MAX_KEYS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  kli_in_if.sink     in_ch,
  kli_out_if.source  out_ch
);

  localparam int AW = $clog2(MAX_KEYS);
  localparam int CW = $clog2(MAX_KEYS + 1);
  localparam int PW = DATA_W + FRAC_W + 2;

  // sequencer and control state
  state_t        state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic          out_valid_r, out_valid_nxt;

  // datapath registers
  logic signed [DATA_W-1:0] t_r, t_nxt;
  key_t                     prev_r, prev_nxt;
  logic signed [DATA_W-1:0] last_v_r, last_v_nxt;
  logic signed [DATA_W-1:0] v0_r, v0_nxt;
  logic signed [DATA_W-1:0] v1_r, v1_nxt;
  logic [DATA_W-1:0]        w_r, w_nxt;
  logic [DATA_W-1:0]        dt_r, dt_nxt;
  logic signed [PW-1:0]     prod_r, prod_nxt;
  logic signed [DATA_W-1:0] res_r, res_nxt;
  logic                     res_empty_r, res_empty_nxt;
  logic signed [DATA_W-1:0] out_value_r, out_value_nxt;
  logic                     out_empty_r, out_empty_nxt;

  // memory and divider hookup
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  key_t              mem_wdata;
  key_t              rd;
  logic              div_start;
  logic              div_done;
  logic [FRAC_W-1:0] div_quo;

  // decoded conditions
  logic                     accept;
  logic                     is_clear, is_add, is_query;
  logic                     full;
  logic                     first_hit, last_hit, seg_hit, scan_end;
  logic                     out_load;
  logic signed [DATA_W:0]   vdiff;

  assign accept   = in_ch.valid && in_ch.ready;
  assign is_clear = in_ch.cmd == CMD_CLEAR;
  assign is_add   = in_ch.cmd == CMD_ADD;
  assign is_query = in_ch.cmd == CMD_QUERY;
  assign full     = count_r >= CW'(MAX_KEYS);

  // compares against the key read in the previous cycle
  assign first_hit = t_r <= rd.kt;
  assign last_hit  = t_r >= rd.kt;
  assign seg_hit   = (t_r >= prev_r.kt) && (t_r <= rd.kt);
  assign scan_end  = idx_r == AW'(count_r - CW'(1));

  assign vdiff    = {v1_r[DATA_W-1], v1_r} - {v0_r[DATA_W-1], v0_r};
  assign out_load = !out_valid_r || out_ch.ready;

  assign mem_wdata = '{kt: in_ch.time_in, kv: in_ch.key_value};

  kli_key_mem #(
    .DEPTH (MAX_KEYS),
    .AW    (AW)
  ) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (AW'(count_r)),
    .wdata   (mem_wdata),
    .re      (mem_re),
    .raddr   (mem_raddr),
    .rdata_r (rd)
  );

  kli_frac_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (dt_r),
    .den    (w_r),
    .done_r (div_done),
    .quo_r  (div_quo)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && is_query) begin
          state_nxt = (count_r == '0) ? S_OUT : S_FIRST;
        end
      end
      S_FIRST: state_nxt = first_hit ? S_OUT : S_LAST;
      S_LAST:  state_nxt = last_hit ? S_OUT : S_SCAN;
      S_SCAN: begin
        if (seg_hit) begin
          state_nxt = S_CHECK;
        end else if (scan_end) begin
          state_nxt = S_OUT;
        end
      end
      S_CHECK: begin
        if ((w_r == '0) || (dt_r >= w_r)) begin
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL:   state_nxt = S_ADD;
      S_ADD:   state_nxt = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_raddr   = '0;
    div_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ch.ready = 1'b1;
        mem_we      = in_ch.valid && is_add && !full;
        mem_re      = in_ch.valid && is_query && (count_r != '0);
      end
      S_FIRST: begin
        // fetch the last key
        mem_re    = !first_hit;
        mem_raddr = AW'(count_r - CW'(1));
      end
      S_LAST: begin
        // start the segment scan at key one
        mem_re    = !last_hit;
        mem_raddr = AW'(1);
      end
      S_SCAN: begin
        mem_re    = !seg_hit && !scan_end;
        mem_raddr = idx_r + AW'(1);
      end
      S_CHECK: begin
        div_start = (w_r != '0) && (dt_r < w_r);
      end
      default: begin
      end
    endcase
  end

  // datapath next values
  always_comb begin
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    t_nxt         = t_r;
    prev_nxt      = prev_r;
    last_v_nxt    = last_v_r;
    v0_nxt        = v0_r;
    v1_nxt        = v1_r;
    w_nxt         = w_r;
    dt_nxt        = dt_r;
    prod_nxt      = prod_r;
    res_nxt       = res_r;
    res_empty_nxt = res_empty_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_value_nxt = out_value_r;
    out_empty_nxt = out_empty_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (is_clear) begin
            count_nxt = '0;
          end else if (is_add && !full) begin
            count_nxt = count_r + CW'(1);
          end else if (is_query) begin
            t_nxt         = in_ch.time_in;
            res_nxt       = '0;
            res_empty_nxt = count_r == '0;
          end
        end
      end
      S_FIRST: begin
        prev_nxt = rd;
        res_nxt  = rd.kv;
      end
      S_LAST: begin
        last_v_nxt = rd.kv;
        res_nxt    = rd.kv;
        idx_nxt    = AW'(1);
      end
      S_SCAN: begin
        if (seg_hit) begin
          // segment found: offsets are non-negative and fit 32 bits
          v0_nxt = prev_r.kv;
          v1_nxt = rd.kv;
          w_nxt  = DATA_W'(rd.kt - prev_r.kt);
          dt_nxt = DATA_W'(t_r - prev_r.kt);
        end else begin
          prev_nxt = rd;
          idx_nxt  = idx_r + AW'(1);
          res_nxt  = last_v_r;
        end
      end
      S_CHECK: begin
        // zero-width segment gives its start, the segment end gives v1
        res_nxt = (w_r == '0) ? v0_r : v1_r;
      end
      S_MUL: begin
        prod_nxt = PW'(vdiff * $signed({1'b0, div_quo}));
      end
      S_ADD: begin
        // low bits of the floor shift are the product's middle bits
        res_nxt = v0_r + $signed(prod_r[DATA_W+FRAC_W-1:FRAC_W]);
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          out_empty_nxt = res_empty_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    t_r         <= t_nxt;
    prev_r      <= prev_nxt;
    last_v_r    <= last_v_nxt;
    v0_r        <= v0_nxt;
    v1_r        <= v1_nxt;
    w_r         <= w_nxt;
    dt_r        <= dt_nxt;
    prod_r      <= prod_nxt;
    res_r       <= res_nxt;
    res_empty_r <= res_empty_nxt;
    out_value_r <= out_value_nxt;
    out_empty_r <= out_empty_nxt;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.interp_value = out_value_r;
  assign out_ch.table_empty  = out_empty_r;

  // key count never passes the table size
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_KEYS))
    else $error("key count above table size");

  // an add into a table with room grows it by one
  a_add_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_add && !full) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("add beat did not grow the key count");

  // a query on an empty table goes straight to the result with the flag set
  a_empty_query: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_query && (count_r == '0)) |=>
      ((state_r == S_OUT) && res_empty_r && (res_r == '0)))
    else $error("empty-table query not flagged");

  // the scan index stays inside the stored keys
  a_scan_index: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> ((CW'(idx_r) < count_r) && (idx_r != '0)))
    else $error("scan index outside stored keys");

  // the divider only finishes while the sequencer waits for it
  a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_DIV))
    else $error("divider finished outside its wait state");

endmodule
